// ===== src/tdmh_pkg.sv =====
package tdmh_pkg;

	// Round counts and length counter width
	localparam int PARTIAL_ROUNDS = 6;
	localparam int FINAL_ROUNDS   = 10;
	localparam int LENGTH_BITS    = 16;

	localparam int MAX_ROUNDS = (PARTIAL_ROUNDS > FINAL_ROUNDS) ? PARTIAL_ROUNDS : FINAL_ROUNDS;
	localparam int RND_W      = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
	// Round sum never exceeds (MAX_ROUNDS + 1) * delta
	localparam int SUM_W      = 32 + $clog2(MAX_ROUNDS + 1);

	localparam logic [RND_W-1:0] PARTIAL_LAST = RND_W'(PARTIAL_ROUNDS - 1);
	localparam logic [RND_W-1:0] FINAL_LAST   = RND_W'(FINAL_ROUNDS - 1);

	localparam logic [31:0] TEA_DELTA  = 32'h9E37_79B9;
	localparam logic [31:0] KEY0_RESET = 32'h9464_A485;
	localparam logic [31:0] KEY1_RESET = 32'h542E_1A94;

	// Chunk byte count
	localparam int              CNT_W      = 5;
	localparam logic [CNT_W-1:0] CHUNK_FULL = 5'd16;

	// Configuration register indexes
	localparam int                   CFG_IDX_W     = 1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic start;      // chunk transfer: latch payload, update length
		logic new_name;   // chunk opens a name: reload chain from keys
		logic load;       // build words, seed round state
		logic pack_tail;  // build words from leftover bytes and pad
		logic half_a;     // first half of a round
		logic half_b;     // second half of a round
		logic feed;       // add round state into chain
		logic emit;       // load result register
	} cmd_t;

endpackage

// ===== src/tdmh_chunk_if.sv =====
interface tdmh_chunk_if import tdmh_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [63:0]      bytes_low;
	logic [63:0]      bytes_high;
	logic [CNT_W-1:0] byte_count;
	logic             last_chunk;

	modport source (output valid, bytes_low, bytes_high, byte_count, last_chunk, input ready);
	modport sink   (input valid, bytes_low, bytes_high, byte_count, last_chunk, output ready);
endinterface

// ===== src/tdmh_hash_if.sv =====
interface tdmh_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;
	logic        length_overflow;

	modport source (output valid, hash_value, length_overflow, input ready);
	modport sink   (input valid, hash_value, length_overflow, output ready);
endinterface

// ===== src/tdmh_cfg_if.sv =====
interface tdmh_cfg_if import tdmh_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tdmh_ctrl.sv =====
module tdmh_ctrl import tdmh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	input  logic [CNT_W-1:0] in_count,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	output cmd_t             cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_HALF_A = 3'd2;
	localparam logic [2:0] ST_HALF_B = 3'd3;
	localparam logic [2:0] ST_FEED   = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]       state_q;
	logic [RND_W-1:0] rnd_q;
	logic             in_name_q;
	logic             last_q;
	logic             full_q;
	logic             tail_q;
	logic             out_valid_q;
	logic             pack;
	logic             accept;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	// Pack leftover bytes on the tail pass or on a short last chunk
	assign pack      = tail_q || (last_q && !full_q);

	// Decode commands
	always_comb begin
		cmd           = '0;
		cmd.start     = accept;
		cmd.new_name  = accept && !in_name_q;
		cmd.load      = (state_q == ST_LOAD);
		cmd.pack_tail = pack;
		cmd.half_a    = (state_q == ST_HALF_A);
		cmd.half_b    = (state_q == ST_HALF_B);
		cmd.feed      = (state_q == ST_FEED);
		cmd.emit      = (state_q == ST_EMIT) && out_free;
	end

	// Sequence the rounds of each chunk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			in_name_q   <= 1'b0;
			last_q      <= 1'b0;
			full_q      <= 1'b0;
			tail_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						in_name_q <= 1'b1;
						last_q    <= in_last;
						full_q    <= !in_last || in_count[CNT_W-1];
						tail_q    <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rnd_q   <= pack ? FINAL_LAST : PARTIAL_LAST;
					state_q <= ST_HALF_A;
				end
				ST_HALF_A: begin
					state_q <= ST_HALF_B;
				end
				ST_HALF_B: begin
					if (rnd_q == '0) begin
						state_q <= ST_FEED;
					end else begin
						rnd_q   <= rnd_q - 1'b1;
						state_q <= ST_HALF_A;
					end
				end
				ST_FEED: begin
					if (pack) begin
						state_q <= ST_EMIT;
					end else if (last_q) begin
						tail_q  <= 1'b1;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						in_name_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/tdmh_datapath.sv =====
module tdmh_datapath import tdmh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [63:0]          in_bytes_low,
	input  logic [63:0]          in_bytes_high,
	input  logic [CNT_W-1:0]     in_count,
	input  logic                 in_last,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output logic [63:0]          hash_value,
	output logic                 length_overflow
);

	logic [31:0]            key0_q;
	logic [31:0]            key1_q;
	logic [63:0]            lo_q;
	logic [63:0]            hi_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic                   ovf_q;
	logic [63:0]            chain0_q;
	logic [63:0]            chain1_q;
	logic [63:0]            b0_q;
	logic [63:0]            b1_q;
	logic [SUM_W-1:0]       sum_q;
	logic [3:0][63:0]       w_q;
	logic [63:0]            hash_q;
	logic                   ovf_out_q;

	logic [CNT_W-1:0]       add_cnt;
	logic [LENGTH_BITS-1:0] len_base;
	logic [LENGTH_BITS:0]   len_total;
	logic [3:0][31:0]       cw;
	logic [3:0]             rest;
	logic [63:0]            len64;
	logic [63:0]            pad0;
	logic [63:0]            pad;
	logic [3:0][63:0]       w_next;
	logic [63:0]            sum64;
	logic [63:0]            mix_a;
	logic [63:0]            mix_b;

	assign hash_value      = hash_q;
	assign length_overflow = ovf_out_q;

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= KEY0_RESET;
			key1_q <= KEY1_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY_WORD0: key0_q <= cfg_data;
				REG_KEY_WORD1: key1_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Length accumulation: counts above sixteen and non-last chunks count as sixteen
	assign add_cnt   = (!in_last || in_count[CNT_W-1]) ? CHUNK_FULL : in_count;
	assign len_base  = cmd.new_name ? '0 : len_q;
	assign len_total = {1'b0, len_base} + (LENGTH_BITS+1)'(add_cnt);

	// Word building: full chunk words or leftover bytes over the length pad
	assign cw[0] = lo_q[31:0];
	assign cw[1] = lo_q[63:32];
	assign cw[2] = hi_q[31:0];
	assign cw[3] = hi_q[63:32];
	assign rest  = cnt_q[CNT_W-1] ? 4'd0 : cnt_q[3:0];
	assign len64 = 64'(len_q);
	assign pad0  = len64 | (len64 << 8);
	assign pad   = pad0 | (pad0 << 16);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (!cmd.pack_tail || (2'(k) < rest[3:2])) begin
				w_next[k] = 64'(cw[k]);
			end else if (2'(k) == rest[3:2]) begin
				case (rest[1:0])
					2'd0: w_next[k] = pad;
					2'd1: w_next[k] = {pad[55:0], cw[k][7:0]};
					2'd2: w_next[k] = {pad[47:0], cw[k][7:0], cw[k][15:8]};
					2'd3: w_next[k] = {pad[39:0], cw[k][7:0], cw[k][15:8], cw[k][23:16]};
					default: w_next[k] = pad;
				endcase
			end else begin
				w_next[k] = pad;
			end
		end
	end

	// Round functions, one half round per cycle
	assign sum64 = 64'(sum_q);
	assign mix_a = ((b1_q << 4) + w_q[0]) ^ (b1_q + sum64) ^ ((b1_q >> 5) + w_q[1]);
	assign mix_b = ((b0_q << 4) + w_q[2]) ^ (b0_q + sum64) ^ ((b0_q >> 5) + w_q[3]);

	// Chunk, chain and round registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_q  <= in_bytes_low;
			hi_q  <= in_bytes_high;
			cnt_q <= add_cnt;
			len_q <= len_total[LENGTH_BITS-1:0];
			ovf_q <= (cmd.new_name ? 1'b0 : ovf_q) | len_total[LENGTH_BITS];
			if (cmd.new_name) begin
				chain0_q <= 64'(key0_q);
				chain1_q <= 64'(key1_q);
			end
		end
		if (cmd.load) begin
			w_q   <= w_next;
			b0_q  <= chain0_q;
			b1_q  <= chain1_q;
			sum_q <= SUM_W'(TEA_DELTA);
		end
		if (cmd.half_a) begin
			b0_q <= b0_q + mix_a;
		end
		if (cmd.half_b) begin
			b1_q  <= b1_q + mix_b;
			sum_q <= sum_q + SUM_W'(TEA_DELTA);
		end
		if (cmd.feed) begin
			chain0_q <= chain0_q + b0_q;
			chain1_q <= chain1_q + b1_q;
		end
		if (cmd.emit) begin
			hash_q    <= chain0_q ^ chain1_q;
			ovf_out_q <= ovf_q;
		end
	end

endmodule

// ===== src/tea_davies_meyer_name_hash_top.sv =====
// Channel  Direction  Payload                                       Transfer
// chunk    in         bytes_low, bytes_high, byte_count, last_chunk  valid & ready
// hash     out        hash_value, length_overflow                   valid & ready
// cfg      in         index, data (32-bit key words)                valid & ready
//
// A chunk that is not last goes from transfer to the next ready through a setup state,
// a first and a second half per TEA round on the shared round unit, and one chain add.
// A short last chunk pads its leftover bytes; a 16-byte one adds a tail pass of pad.
// Reset loads the key registers with their defaults; cfg is always ready.
// A held result does not block the next chunk; a second result waits for it.
module tea_davies_meyer_name_hash_top import tdmh_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	tdmh_chunk_if.sink     chunk,
	tdmh_hash_if.source    hash,
	tdmh_cfg_if.sink       cfg
);

	cmd_t cmd;

	// Accept key writes in any cycle
	assign cfg.ready = 1'b1;

	tdmh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chunk.valid),
		.in_last   (chunk.last_chunk),
		.in_count  (chunk.byte_count),
		.in_ready  (chunk.ready),
		.out_ready (hash.ready),
		.out_valid (hash.valid),
		.cmd       (cmd)
	);

	tdmh_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.in_bytes_low    (chunk.bytes_low),
		.in_bytes_high   (chunk.bytes_high),
		.in_count        (chunk.byte_count),
		.in_last         (chunk.last_chunk),
		.cfg_write       (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.hash_value      (hash.hash_value),
		.length_overflow (hash.length_overflow)
	);

endmodule
